>>> sv/lruol_pkg.sv
// Shared types, codes and the microcode table of the LRU order list.
`default_nettype none

package lruol_pkg;

    // Default pool size and the fixed field widths of the command and result words.
    localparam int unsigned ENTRIES_DEF = 64;
    localparam int unsigned OPCODE_W    = 3;
    localparam int unsigned ENTRY_W     = 6;

    // Command opcodes.
    localparam logic [OPCODE_W-1:0] OP_CLEAR      = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_PUSH_HEAD  = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_REMOVE     = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_EVICT_TAIL = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_TOUCH      = 3'd4;

    // Command word: one per accepted start.
    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [ENTRY_W-1:0]  entry;
    } cmd_word_t;

    // Result word: one per command.
    typedef struct packed {
        logic [ENTRY_W-1:0] victim;
        logic               victim_valid;
        logic               list_empty;
    } result_word_t;

    // Microcode step addresses.
    localparam int unsigned STEP_W = 4;
    typedef logic [STEP_W-1:0] step_t;

    localparam step_t ST_CLEAR = 4'd0;
    localparam step_t ST_NOP   = 4'd1;
    localparam step_t ST_RM1   = 4'd2;
    localparam step_t ST_RM2   = 4'd3;
    localparam step_t ST_RL1   = 4'd4;
    localparam step_t ST_RL2   = 4'd5;
    localparam step_t ST_TC1   = 4'd6;
    localparam step_t ST_AD1   = 4'd7;
    localparam step_t ST_AD2   = 4'd8;

    // Next-link write address and data selects.
    typedef enum logic [1:0] {NA_NONE, NA_A, NA_P} nw_addr_t;
    typedef enum logic [1:0] {ND_N, ND_NIL, ND_HEAD} nw_data_t;

    // Prev-link write address and data selects.
    typedef enum logic [1:0] {PA_NONE, PA_A, PA_N, PA_HEAD} pw_addr_t;
    typedef enum logic [1:0] {PD_P, PD_NIL, PD_A} pw_data_t;

    // Head and tail pointer updates.
    typedef enum logic [2:0] {
        H_KEEP, H_N_IF_PNIL, H_NIL_IF_PNIL, H_A, H_NIL
    } head_op_t;
    typedef enum logic [2:0] {
        T_KEEP, T_P_IF_NNIL, T_P, T_A_IF_HNIL, T_NIL
    } tail_op_t;

    // Sequencing: fall through, skip to target when the prev link is null, or finish.
    typedef enum logic [1:0] {BR_NEXT, BR_SKIP_PNIL, BR_DONE} br_t;

    // One control word of the microprogram.
    typedef struct packed {
        nw_addr_t nw_addr;
        nw_data_t nw_data;
        pw_addr_t pw_addr;
        pw_data_t pw_data;
        head_op_t head_op;
        tail_op_t tail_op;
        logic     victim;
        br_t      br;
        step_t    target;
    } ucode_t;

    // Microprogram table.
    function automatic ucode_t ucode_rom(input step_t step);
        ucode_t w;
        w.nw_addr = NA_NONE;
        w.nw_data = ND_NIL;
        w.pw_addr = PA_NONE;
        w.pw_data = PD_NIL;
        w.head_op = H_KEEP;
        w.tail_op = T_KEEP;
        w.victim  = 1'b0;
        w.br      = BR_DONE;
        w.target  = ST_NOP;
        unique case (step)
            ST_CLEAR:
            begin
                w.head_op = H_NIL;
                w.tail_op = T_NIL;
            end
            ST_NOP:
            begin
                w.br = BR_DONE;
            end
            // Unlink: bridge the neighbors around the entry.
            ST_RM1:
            begin
                w.nw_addr = NA_P;
                w.nw_data = ND_N;
                w.pw_addr = PA_N;
                w.pw_data = PD_P;
                w.head_op = H_N_IF_PNIL;
                w.tail_op = T_P_IF_NNIL;
                w.br      = BR_NEXT;
            end
            ST_RM2:
            begin
                w.nw_addr = NA_A;
                w.pw_addr = PA_A;
            end
            // Evict the tail: its predecessor becomes the new tail.
            ST_RL1:
            begin
                w.nw_addr = NA_P;
                w.nw_data = ND_NIL;
                w.head_op = H_NIL_IF_PNIL;
                w.tail_op = T_P;
                w.br      = BR_NEXT;
            end
            ST_RL2:
            begin
                w.nw_addr = NA_A;
                w.pw_addr = PA_A;
                w.victim  = 1'b1;
            end
            // Touch: leave the head alone, otherwise unlink and fall into the push to head.
            ST_TC1:
            begin
                w.nw_addr = NA_P;
                w.nw_data = ND_N;
                w.pw_addr = PA_N;
                w.pw_data = PD_P;
                w.tail_op = T_P_IF_NNIL;
                w.br      = BR_SKIP_PNIL;
                w.target  = ST_NOP;
            end
            ST_AD1:
            begin
                w.nw_addr = NA_A;
                w.nw_data = ND_HEAD;
                w.pw_addr = PA_A;
                w.pw_data = PD_NIL;
                w.br      = BR_NEXT;
            end
            ST_AD2:
            begin
                w.pw_addr = PA_HEAD;
                w.pw_data = PD_A;
                w.tail_op = T_A_IF_HNIL;
                w.head_op = H_A;
            end
            default:
            begin
                w.br = BR_DONE;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

>>> sv/lruol_link_ram.sv
// Prev and next link stores of the LRU order list, one write port each and a shared read address.
`default_nettype none

module lruol_link_ram #(
    parameter int unsigned ENTRIES = lruol_pkg::ENTRIES_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rd_en,
    input  wire logic [$clog2(ENTRIES+1)-1:0]    rd_addr,
    output logic      [$clog2(ENTRIES+1)-1:0]    prev_rd,
    output logic      [$clog2(ENTRIES+1)-1:0]    next_rd,
    input  wire logic                            prev_we,
    input  wire logic [$clog2(ENTRIES+1)-1:0]    prev_addr,
    input  wire logic [$clog2(ENTRIES+1)-1:0]    prev_wdata,
    input  wire logic                            next_we,
    input  wire logic [$clog2(ENTRIES+1)-1:0]    next_addr,
    input  wire logic [$clog2(ENTRIES+1)-1:0]    next_wdata
);
    import lruol_pkg::*;

    localparam int unsigned LINK_W = $clog2(ENTRIES + 1);
    localparam int unsigned IDX_W  = $clog2(ENTRIES);

    logic [LINK_W-1:0] prev_mem [ENTRIES];
    logic [LINK_W-1:0] next_mem [ENTRIES];

    // Prev link store.
    always_ff @(posedge clk)
    begin
        if (prev_we)
        begin
            prev_mem[prev_addr[IDX_W-1:0]] <= prev_wdata;
        end
        if (rd_en)
        begin
            prev_rd <= prev_mem[rd_addr[IDX_W-1:0]];
        end
    end

    // Next link store.
    always_ff @(posedge clk)
    begin
        if (next_we)
        begin
            next_mem[next_addr[IDX_W-1:0]] <= next_wdata;
        end
        if (rd_en)
        begin
            next_rd <= next_mem[rd_addr[IDX_W-1:0]];
        end
    end

endmodule

`default_nettype wire

>>> sv/lru_order_list.sv
// Top level of the LRU order list: microcoded sequencer over the link stores.
//
// Keeps a recency order over ENTRIES entries as a doubly linked list with
// head (most recent) and tail (least recent) pointers. A command word is
// taken when start is high and busy is low; busy then stays high while a
// short microprogram runs, one control word per cycle, and falls in the
// cycle where done pulses for one cycle with the result word. The result
// must be captured in that cycle, and a new start may be given in it.
// Clear and invalid or ignored commands run just a finishing step; push to
// head runs steps AD1, AD2, remove RM1, RM2, tail eviction RL1, RL2, touch
// TC1, AD1, AD2, or TC1 and a finishing step when the entry is head. Each
// link store has one write port, so the link updates of a command go out
// one step at a time. The link stores need no clearing after reset.
`default_nettype none

module lru_order_list #(
    parameter int unsigned ENTRIES = lruol_pkg::ENTRIES_DEF
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire lruol_pkg::cmd_word_t    cmd,
    output logic                         busy,
    output logic                         done,
    output lruol_pkg::result_word_t      result
);
    import lruol_pkg::*;

    localparam int unsigned LINK_W = $clog2(ENTRIES + 1);
    localparam int unsigned CMP_W  = (LINK_W > ENTRY_W) ? LINK_W : ENTRY_W;
    localparam logic [LINK_W-1:0] NIL = LINK_W'(ENTRIES);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    step_t             pc_reg, pc_next;
    logic [LINK_W-1:0] a_reg, a_next;
    logic [LINK_W-1:0] head_reg, head_next;
    logic [LINK_W-1:0] tail_reg, tail_next;
    result_word_t      result_reg, result_next;

    logic              accept;
    logic [CMP_W-1:0]  entry_ext;
    logic              entry_ok;
    logic [LINK_W-1:0] start_addr;
    step_t             dispatch;
    ucode_t            uw;
    logic [LINK_W-1:0] prev_rd, next_rd;
    logic              p_nil, n_nil, h_nil;
    logic              skip, act, finish;
    logic              prev_we, next_we;
    logic [LINK_W-1:0] prev_addr, prev_wdata, next_addr, next_wdata;

    // Command decode and dispatch into the microprogram.
    always_comb
    begin
        accept    = start && !busy_reg;
        entry_ext = CMP_W'(cmd.entry);
        entry_ok  = entry_ext < CMP_W'(ENTRIES);
        if (cmd.opcode == OP_EVICT_TAIL)
        begin
            start_addr = tail_reg;
        end
        else
        begin
            start_addr = LINK_W'(entry_ext);
        end
        unique case (cmd.opcode)
            OP_CLEAR:      dispatch = ST_CLEAR;
            OP_PUSH_HEAD:  dispatch = entry_ok ? ST_AD1 : ST_NOP;
            OP_REMOVE:     dispatch = entry_ok ? ST_RM1 : ST_NOP;
            OP_EVICT_TAIL: dispatch = (tail_reg < NIL) ? ST_RL1 : ST_NOP;
            OP_TOUCH:      dispatch = entry_ok ? ST_TC1 : ST_NOP;
            default:       dispatch = ST_NOP;
        endcase
    end

    // Control word and step conditions.
    always_comb
    begin
        uw     = ucode_rom(pc_reg);
        p_nil  = prev_rd == NIL;
        n_nil  = next_rd == NIL;
        h_nil  = head_reg == NIL;
        skip   = busy_reg && (uw.br == BR_SKIP_PNIL) && p_nil;
        act    = busy_reg && !skip;
        finish = act && (uw.br == BR_DONE);
    end

    // Link write ports; a write aimed at the null marker is dropped.
    always_comb
    begin
        case (uw.nw_addr)
            NA_A:    next_addr = a_reg;
            NA_P:    next_addr = prev_rd;
            default: next_addr = NIL;
        endcase
        case (uw.nw_data)
            ND_N:    next_wdata = next_rd;
            ND_HEAD: next_wdata = head_reg;
            default: next_wdata = NIL;
        endcase
        case (uw.pw_addr)
            PA_A:    prev_addr = a_reg;
            PA_N:    prev_addr = next_rd;
            PA_HEAD: prev_addr = head_reg;
            default: prev_addr = NIL;
        endcase
        case (uw.pw_data)
            PD_P:    prev_wdata = prev_rd;
            PD_A:    prev_wdata = a_reg;
            default: prev_wdata = NIL;
        endcase
        next_we = act && (uw.nw_addr != NA_NONE) && (next_addr < NIL);
        prev_we = act && (uw.pw_addr != PA_NONE) && (prev_addr < NIL);
    end

    // Head and tail pointer updates.
    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        if (act)
        begin
            case (uw.head_op)
                H_N_IF_PNIL:   if (p_nil) head_next = next_rd;
                H_NIL_IF_PNIL: if (p_nil) head_next = NIL;
                H_A:           head_next = a_reg;
                H_NIL:         head_next = NIL;
                default:       head_next = head_reg;
            endcase
            case (uw.tail_op)
                T_P_IF_NNIL:   if (n_nil) tail_next = prev_rd;
                T_P:           tail_next = prev_rd;
                T_A_IF_HNIL:   if (h_nil) tail_next = a_reg;
                T_NIL:         tail_next = NIL;
                default:       tail_next = tail_reg;
            endcase
        end
    end

    // Sequencer and result word.
    always_comb
    begin
        busy_next   = busy_reg;
        pc_next     = pc_reg;
        a_next      = a_reg;
        done_next   = finish;
        result_next = result_reg;
        if (accept)
        begin
            busy_next = 1'b1;
            pc_next   = dispatch;
            a_next    = start_addr;
        end
        else if (skip)
        begin
            pc_next = uw.target;
        end
        else if (finish)
        begin
            busy_next = 1'b0;
        end
        else if (busy_reg)
        begin
            pc_next = pc_reg + STEP_W'(1);
        end
        if (finish)
        begin
            result_next.victim       = uw.victim ? ENTRY_W'(CMP_W'(a_reg)) : '0;
            result_next.victim_valid = uw.victim;
            result_next.list_empty   = head_next == NIL;
        end
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            pc_reg   <= ST_NOP;
            head_reg <= NIL;
            tail_reg <= NIL;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            pc_reg   <= pc_next;
            head_reg <= head_next;
            tail_reg <= tail_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        a_reg      <= a_next;
        result_reg <= result_next;
    end

    // Link stores; both links of the addressed entry are read when a word is taken.
    lruol_link_ram #(
        .ENTRIES(ENTRIES)
    ) u_link_ram (
        .clk        (clk),
        .rd_en      (accept),
        .rd_addr    (start_addr),
        .prev_rd    (prev_rd),
        .next_rd    (next_rd),
        .prev_we    (prev_we),
        .prev_addr  (prev_addr),
        .prev_wdata (prev_wdata),
        .next_we    (next_we),
        .next_addr  (next_addr),
        .next_wdata (next_wdata)
    );

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire
